[design/sgsp_pkg.sv]
// Shared types, constants and tables of the serial GPIO / SPI command parser.
// No dependencies; every other design file imports this package.
`default_nettype none
package sgsp_pkg;

	localparam int PIN_TOTAL   = 28;
	localparam int VERSION_LEN = 22;
	localparam int PIN_W       = $clog2(PIN_TOTAL);
	localparam int VEC_W       = 28;
	localparam int BEAT_W      = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [VEC_W-1:0] SPI_PINS = 28'hE00;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A_LC  = 8'h61;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_N     = 8'h4E;

	localparam logic [7:0] VERSION_ROM [31] = '{
		8'h52, 8'h54, 8'h6B, 8'h2E, 8'h47, 8'h50, 8'h49, 8'h4F, 8'h20, 8'h76, 8'h32,
		8'h20, 8'h30, 8'h38, 8'h2F, 8'h30, 8'h34, 8'h2F, 8'h32, 8'h30, 8'h32, 8'h32,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
	};

	typedef struct packed {
		logic             command;
		logic [7:0]       data_byte;
		logic [VEC_W-1:0] pin_levels;
	} in_item_t;

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             spi_send_valid;
		logic [7:0]       spi_send_byte;
		logic [VEC_W-1:0] drive_level;
		logic [VEC_W-1:0] drive_enable;
		logic [VEC_W-1:0] pull_up_enable;
		logic [VEC_W-1:0] pull_down_enable;
		logic             spi_active;
		logic             last;
	} out_item_t;

	// Pin configuration as seen on the outputs
	typedef struct packed {
		logic [VEC_W-1:0] level;
		logic [VEC_W-1:0] enable;
		logic [VEC_W-1:0] pull_up;
		logic [VEC_W-1:0] pull_down;
		logic             spi;
	} pin_cfg_t;

	typedef enum logic [2:0] {
		JOB_IDLE    = 3'd0,
		JOB_READ    = 3'd1,
		JOB_REPLY   = 3'd2,
		JOB_VERSION = 3'd3,
		JOB_SPI     = 3'd4
	} job_kind_t;

	// One classified item handed from front to back
	typedef struct packed {
		job_kind_t        kind;
		logic             crlf;
		logic [PIN_W-1:0] pin;
		logic             level;
		logic [7:0]       data;
		pin_cfg_t         cfg;
	} job_t;

endpackage
`default_nettype wire

[design/sgsp_front.sv]
// Front end: accepts input beats, runs the command parser and pin state, and
// pushes one classified job per item into the queue. Depends on sgsp_pkg.
`default_nettype none
module sgsp_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  sgsp_pkg::in_item_t in_data,
	input  wire              full,
	output logic             push,
	output sgsp_pkg::job_t   job
);
	import sgsp_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_BASIC_OP = 5'b00010,
		PH_HEX_HI   = 5'b00100,
		PH_HEX_LO   = 5'b01000,
		PH_REPLY    = 5'b10000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             enh_q, enh_d;
	logic [PIN_W-1:0] cur_q, cur_d;
	logic [3:0]       hi_q, hi_d;
	logic [VEC_W-1:0] bound_q, bound_d;
	pin_cfg_t         cfg_q, cfg_d;

	logic             do_op;
	logic             do_claim;
	logic [7:0]       b;
	logic [7:0]       hv;
	logic [7:0]       pin_off;
	logic             is_letter;
	logic             is_op;
	logic [VEC_W-1:0] m;

	function automatic logic [7:0] hex_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return 8'(c - CH_0);
		return 8'(c - 8'd55);
	endfunction

	assign in_ready = !full;
	assign push     = in_valid && !full;

	assign b         = in_data.data_byte;
	assign hv        = hex_value(b);
	assign pin_off   = 8'(b - CH_A_LC);
	assign is_letter = (b >= CH_A_LC) && (pin_off < 8'(PIN_TOTAL));
	assign is_op     = (b == CH_0) || (b == CH_1) || (b == CH_I) || (b == CH_O) ||
	                   (b == CH_QUERY) || (b == CH_U) || (b == CH_D) || (b == CH_N);
	assign m         = VEC_W'(1) << cur_q;

	always_comb begin
		phase_d   = phase_q;
		enh_d     = enh_q;
		cur_d     = cur_q;
		hi_d      = hi_q;
		bound_d   = bound_q;
		cfg_d     = cfg_q;
		do_op     = 1'b0;
		do_claim  = 1'b0;
		job       = '0;
		job.kind  = JOB_IDLE;

		if (in_data.command) begin
			if (phase_q == PH_REPLY) begin
				job.kind = JOB_REPLY;
				job.data = b;
				phase_d  = PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_REPLY: begin
				end
				PH_BASIC_OP: begin
					phase_d = PH_IDLE;
					do_op   = 1'b1;
				end
				PH_HEX_HI: begin
					hi_d    = hv[3:0];
					phase_d = PH_HEX_LO;
				end
				PH_HEX_LO: begin
					job.kind = JOB_SPI;
					job.data = {hi_q, 4'b0000} | hv;
					phase_d  = PH_REPLY;
				end
				default: begin
					phase_d = PH_IDLE;
					priority if (is_letter) begin
						cur_d = pin_off[PIN_W-1:0];
						if (!enh_q)
							phase_d = PH_BASIC_OP;
					end else if (enh_q && is_op) begin
						do_op = 1'b1;
						cur_d = (cur_q == PIN_W'(PIN_TOTAL - 1)) ? '0 : cur_q + 1'b1;
					end else if (enh_q && (b == CH_S || b == CH_TILDE)) begin
						do_claim = 1'b1;
						if (b == CH_TILDE)
							phase_d = PH_HEX_HI;
					end else if (b == CH_V) begin
						job.kind = JOB_VERSION;
					end else if (b == CH_HASH) begin
						enh_d = 1'b1;
					end else begin
						// drop unknown bytes
					end
				end
			endcase
		end

		if (do_claim && !cfg_q.spi) begin
			bound_d         = bound_q & ~SPI_PINS;
			cfg_d.level     = cfg_q.level & ~SPI_PINS;
			cfg_d.enable    = cfg_q.enable & ~SPI_PINS;
			cfg_d.pull_up   = cfg_q.pull_up & ~SPI_PINS;
			cfg_d.pull_down = cfg_q.pull_down & ~SPI_PINS;
			cfg_d.spi       = 1'b1;
		end

		if (do_op) begin
			// bind a fresh pin: input, no pull, latch low
			if ((bound_q & m) == '0) begin
				if ((m & SPI_PINS) != '0)
					cfg_d.spi = 1'b0;
				cfg_d.level     = cfg_d.level & ~m;
				cfg_d.enable    = cfg_d.enable & ~m;
				cfg_d.pull_up   = cfg_d.pull_up & ~m;
				cfg_d.pull_down = cfg_d.pull_down & ~m;
				bound_d         = bound_q | m;
			end
			unique case (b)
				CH_0: cfg_d.level = cfg_d.level & ~m;
				CH_1: cfg_d.level = cfg_d.level | m;
				CH_O: cfg_d.enable = cfg_d.enable | m;
				CH_D: begin
					cfg_d.pull_down = cfg_d.pull_down | m;
					cfg_d.pull_up   = cfg_d.pull_up & ~m;
				end
				CH_U: begin
					cfg_d.pull_up   = cfg_d.pull_up | m;
					cfg_d.pull_down = cfg_d.pull_down & ~m;
				end
				CH_N: begin
					cfg_d.pull_up   = cfg_d.pull_up & ~m;
					cfg_d.pull_down = cfg_d.pull_down & ~m;
				end
				CH_I: begin
					cfg_d.enable = cfg_d.enable & ~m;
					if (!enh_q) begin
						cfg_d.pull_up   = cfg_d.pull_up & ~m;
						cfg_d.pull_down = cfg_d.pull_down & ~m;
					end
				end
				CH_QUERY: begin
					job.kind  = JOB_READ;
					job.pin   = cur_q;
					job.level = (in_data.pin_levels & m) != '0;
					job.crlf  = !enh_q;
				end
				default: begin
				end
			endcase
		end

		job.cfg = cfg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			enh_q   <= 1'b0;
			cur_q   <= '0;
			hi_q    <= '0;
			bound_q <= '0;
			cfg_q   <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			enh_q   <= enh_d;
			cur_q   <= cur_d;
			hi_q    <= hi_d;
			bound_q <= bound_d;
			cfg_q   <= cfg_d;
		end
	end

endmodule
`default_nettype wire

[design/sgsp_queue.sv]
// Small job queue between parser front end and response back end.
// Depends on sgsp_pkg for the job type and depth.
`default_nettype none
module sgsp_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  sgsp_pkg::job_t push_job,
	output logic           full,
	input  wire            pop,
	output logic           head_valid,
	output sgsp_pkg::job_t head
);
	import sgsp_pkg::*;

	job_t              slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/sgsp_back.sv]
// Back end: expands each queued job into its result beats through an output
// register, one beat per cycle unless out_ready stalls. Depends on sgsp_pkg.
`default_nettype none
module sgsp_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               head_valid,
	input  sgsp_pkg::job_t    head,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_ready,
	output sgsp_pkg::out_item_t out_data
);
	import sgsp_pkg::*;

	logic [BEAT_W-1:0] idx_q;
	logic [BEAT_W-1:0] beats;
	logic              last_beat;
	logic              load;
	out_item_t         beat;
	out_item_t         out_q;
	logic              out_valid_q;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v >= 4'd10)
			return 8'(8'h41 + 8'(v) - 8'd10);
		return 8'(CH_0 + 8'(v));
	endfunction

	always_comb begin
		unique case (head.kind)
			JOB_READ:    beats = head.crlf ? BEAT_W'(4) : BEAT_W'(2);
			JOB_REPLY:   beats = BEAT_W'(2);
			JOB_VERSION: beats = BEAT_W'(VERSION_LEN);
			default:     beats = BEAT_W'(1);
		endcase
	end

	assign last_beat = idx_q == beats - 1'b1;
	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && last_beat;

	always_comb begin
		beat                  = '0;
		beat.drive_level      = head.cfg.level;
		beat.drive_enable     = head.cfg.enable;
		beat.pull_up_enable   = head.cfg.pull_up;
		beat.pull_down_enable = head.cfg.pull_down;
		beat.spi_active       = head.cfg.spi;
		beat.last             = last_beat;
		unique case (head.kind)
			JOB_READ: begin
				beat.tx_valid = 1'b1;
				unique case (idx_q[1:0])
					2'd0:    beat.tx_byte = 8'(CH_A_LC + 8'(head.pin));
					2'd1:    beat.tx_byte = head.level ? CH_1 : CH_0;
					2'd2:    beat.tx_byte = CH_CR;
					default: beat.tx_byte = CH_LF;
				endcase
			end
			JOB_REPLY: begin
				beat.tx_valid = 1'b1;
				beat.tx_byte  = idx_q[0] ? hex_char(head.data[3:0]) : hex_char(head.data[7:4]);
			end
			JOB_VERSION: begin
				beat.tx_valid = 1'b1;
				beat.tx_byte  = VERSION_ROM[idx_q];
			end
			JOB_SPI: begin
				beat.spi_send_valid = 1'b1;
				beat.spi_send_byte  = head.data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= last_beat ? '0 : idx_q + 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

[design/serial_gpio_spi_command_parser.sv]
// Serial GPIO / SPI command parser, top level: front end, job queue, back end.
// Depends on sgsp_pkg, sgsp_front, sgsp_queue and sgsp_back.
//
// Each input beat (a serial byte or an SPI reply byte) is parsed in the cycle
// it is accepted, so the input side takes one beat per clock while the
// four-entry job queue has room. Each item yields 1 to VERSION_LEN result
// beats (a version query gives VERSION_LEN, a pin read 2 or 4, a hex reply 2,
// anything else 1); the back end sends one beat per clock from its output
// register while out_ready does not stall it. Every result beat carries the
// pin configuration as it stood after its item, and last marks the final
// beat of each item. There is no reset sweep.
`default_nettype none
module serial_gpio_spi_command_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  sgsp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output sgsp_pkg::out_item_t out_data
);
	import sgsp_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head;

	sgsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.full     (full),
		.push     (push),
		.job      (push_job)
	);

	sgsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sgsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire
